>>> src/pac_pkg.sv
// Package for the polygon area and centroid block.
// Holds payload structs, controller/datapath command and status structs,
// the state and divide-select enums, and fixed widths. No dependencies.
package pac_pkg;

  localparam int COORD_BITS = 12;
  localparam int CFG_W      = 13;
  localparam int OUT_W      = 20;
  localparam int AREA_W     = 26;
  localparam int Q_BITS     = 21;
  localparam int PROD_W     = 2 * COORD_BITS + 1;
  localparam int AB_W       = COORD_BITS + 1;

  localparam logic [CFG_W-1:0]  CFG_RESET = 13'd4096;
  localparam logic [OUT_W-1:0]  OUT_MAX   = 20'hFFFFF;
  localparam logic [AREA_W-1:0] AREA_MAX  = 26'h3FFFFFF;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] vertex_x;
    logic [COORD_BITS-1:0] vertex_y;
    logic                  last_vertex;
  } in_t;

  typedef struct packed {
    logic              skipped;
    logic [AREA_W-1:0] area_twice;
    logic [OUT_W-1:0]  centroid_x;
    logic [OUT_W-1:0]  centroid_y;
    logic [OUT_W-1:0]  mean_x;
    logic [OUT_W-1:0]  mean_y;
    logic              on_border;
    logic              degenerate;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_CLOSE_MUL,
    S_CLOSE_ACC,
    S_DIV_START,
    S_DIV_WAIT,
    S_LOAD
  } state_t;

  typedef enum logic [1:0] {
    SEL_CX,
    SEL_CY,
    SEL_MX,
    SEL_MY
  } div_sel_t;

  typedef struct packed {
    logic     take;
    logic     edge_acc;
    logic     close_mul;
    logic     div_start;
    logic     div_store;
    div_sel_t div_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic last_vertex;
    logic short_poly;
    logic div_busy;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> src/pac_divider.sv
// Restoring divider, one quotient bit per cycle, 21-bit quotient saturated
// to 20 bits. Depends on pac_pkg.
module pac_divider import pac_pkg::*; #(
  parameter int N_W = 64,
  parameter int D_W = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [N_W-1:0]   num,
  input  logic [D_W-1:0]   den,
  output logic             busy,
  output logic             done,
  output logic [OUT_W-1:0] quo
);

  logic [N_W-1:0]    rem;
  logic [N_W-1:0]    dsh;
  logic [Q_BITS-1:0] q;
  logic [4:0]        cnt;
  logic              sat;
  logic              ge;

  assign ge  = rem >= dsh;
  assign quo = (sat || q[Q_BITS-1]) ? OUT_MAX : q[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(Q_BITS);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= N_W'(den) << (Q_BITS - 1);
      q   <= '0;
      sat <= N_W'(num >> Q_BITS) >= N_W'(den);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q   <= {q[Q_BITS-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule

>>> src/pac_datapath.sv
// Datapath: vertex registers, shoelace and moment accumulators, divide
// operand selection, result and output registers. Depends on pac_pkg, pac_divider.
module pac_datapath import pac_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          status,
  input  in_t              in_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data
);

  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W   = COORD_BITS + CNT_W;
  localparam int CROSS_W = PROD_W + CNT_W;
  localparam int MP_W    = AB_W + 1 + PROD_W;
  localparam int MOM_W   = MP_W + CNT_W;
  localparam int DEN_W   = CROSS_W + 2;
  localparam int D_W     = DEN_W + 1;
  localparam int N_W     = MOM_W + 10;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

  logic [CFG_W-1:0]      image_width, image_height;
  logic [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic [CNT_W-1:0]      vertex_count;
  logic [SUM_W-1:0]      sum_x, sum_y;
  logic signed [CROSS_W-1:0] cross_sum;
  logic signed [MOM_W-1:0]   moment_x, moment_y;
  logic                  border_hit, last_flag, edge_valid;
  logic signed [PROD_W-1:0]  c_reg;
  logic [AB_W-1:0]       ab_x, ab_y;
  logic [OUT_W-1:0]      cx_q, cy_q, mx_q, my_q;

  logic [COORD_BITS-1:0] bx, by;
  logic [2*COORD_BITS-1:0] prod_a, prod_b;
  logic signed [PROD_W-1:0] c_next;
  logic signed [MP_W-1:0]   mprod_x, mprod_y;
  logic [CFG_W:0]        wb, hb;
  logic                  hit;
  logic                  cross_neg, mneg, force_zero;
  logic [CROSS_W-1:0]    cross_mag;
  logic [DEN_W-1:0]      den3;
  logic signed [MOM_W-1:0] mom;
  logic [MOM_W-1:0]      mmag;
  logic [N_W-1:0]        div_n;
  logic [D_W-1:0]        div_d;
  logic [OUT_W-1:0]      quo;
  logic                  div_busy, div_done;
  logic [SUM_W-1:0]      sum_sel;

  assign bx     = cmd.close_mul ? first_x : in_data.vertex_x;
  assign by     = cmd.close_mul ? first_y : in_data.vertex_y;
  assign prod_a = prev_x * by;
  assign prod_b = bx * prev_y;
  assign c_next = $signed({1'b0, prod_a}) - $signed({1'b0, prod_b});

  assign mprod_x = $signed({1'b0, ab_x}) * c_reg;
  assign mprod_y = $signed({1'b0, ab_y}) * c_reg;

  assign wb  = {1'b0, image_width} - (CFG_W + 1)'(2);
  assign hb  = {1'b0, image_height} - (CFG_W + 1)'(2);
  assign hit = (in_data.vertex_x == COORD_BITS'(1)) || (in_data.vertex_y == COORD_BITS'(1))
            || ((CFG_W + 1)'(in_data.vertex_x) == wb)
            || ((CFG_W + 1)'(in_data.vertex_y) == hb);

  assign cross_neg = cross_sum[CROSS_W-1];
  assign cross_mag = cross_neg ? CROSS_W'(-cross_sum) : CROSS_W'(cross_sum);
  assign den3      = {2'b00, cross_mag} + {1'b0, cross_mag, 1'b0};
  assign mom       = (cmd.div_sel == SEL_CX) ? moment_x : moment_y;
  assign mneg      = mom[MOM_W-1];
  assign mmag      = mneg ? MOM_W'(-mom) : MOM_W'(mom);
  assign force_zero = (cross_sum == '0) || (mneg != cross_neg);
  assign sum_sel   = (cmd.div_sel == SEL_MX) ? sum_x : sum_y;

  always_comb begin
    unique case (cmd.div_sel)
      SEL_CX, SEL_CY: begin
        div_n = {mmag, 9'd0} + N_W'(den3);
        div_d = {den3, 1'b0};
      end
      default: begin
        div_n = N_W'({sum_sel, 9'd0}) + N_W'(vertex_count);
        div_d = D_W'({vertex_count, 1'b0});
      end
    endcase
  end

  pac_divider #(.N_W(N_W), .D_W(D_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_n),
    .den   (div_d),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  assign status.last_vertex = last_flag;
  assign status.short_poly  = vertex_count < CNT_W'(3);
  assign status.div_busy    = div_busy;
  assign status.div_done    = div_done;
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_RESET;
      image_height <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      first_x      <= '0;
      first_y      <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      vertex_count <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      cross_sum    <= '0;
      moment_x     <= '0;
      moment_y     <= '0;
      border_hit   <= 1'b0;
      last_flag    <= 1'b0;
      edge_valid   <= 1'b0;
    end else begin
      if (cmd.take) begin
        last_flag  <= in_data.last_vertex;
        edge_valid <= 1'b0;
        if (vertex_count < MAX_CNT) begin
          if (vertex_count == '0) begin
            first_x <= in_data.vertex_x;
            first_y <= in_data.vertex_y;
          end else begin
            edge_valid <= 1'b1;
          end
          prev_x       <= in_data.vertex_x;
          prev_y       <= in_data.vertex_y;
          sum_x        <= sum_x + SUM_W'(in_data.vertex_x);
          sum_y        <= sum_y + SUM_W'(in_data.vertex_y);
          border_hit   <= border_hit | hit;
          vertex_count <= vertex_count + CNT_W'(1);
        end
      end
      if (cmd.close_mul) begin
        edge_valid <= 1'b1;
      end
      if (cmd.edge_acc) begin
        edge_valid <= 1'b0;
        if (edge_valid) begin
          cross_sum <= cross_sum + CROSS_W'(c_reg);
          moment_x  <= moment_x + MOM_W'(mprod_x);
          moment_y  <= moment_y + MOM_W'(mprod_y);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take || cmd.close_mul) begin
      c_reg <= c_next;
      ab_x  <= AB_W'(prev_x) + AB_W'(bx);
      ab_y  <= AB_W'(prev_y) + AB_W'(by);
    end
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        SEL_CX: cx_q <= force_zero ? '0 : quo;
        SEL_CY: cy_q <= force_zero ? '0 : quo;
        SEL_MX: mx_q <= quo;
        SEL_MY: my_q <= quo;
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_data <= '0;
      if (status.short_poly) begin
        out_data.skipped <= 1'b1;
      end else begin
        out_data.area_twice <= (cross_mag > CROSS_W'(AREA_MAX)) ? AREA_MAX
                                                                : AREA_W'(cross_mag);
        out_data.centroid_x <= cx_q;
        out_data.centroid_y <= cy_q;
        out_data.mean_x     <= mx_q;
        out_data.mean_y     <= my_q;
        out_data.on_border  <= border_hit;
        out_data.degenerate <= cross_sum == '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> src/pac_ctrl.sv
// Controller state machine: sequences vertex intake, polygon closing, the
// four divisions and the result load. Depends on pac_pkg.
module pac_ctrl import pac_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t   state, state_next;
  div_sel_t sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= SEL_CX;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next  = state;
    sel_next    = sel;
    cmd         = '0;
    cmd.div_sel = sel;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.edge_acc = 1'b1;
        if (!status.last_vertex) begin
          state_next = S_IDLE;
        end else if (status.short_poly) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_CLOSE_MUL;
        end
      end
      S_CLOSE_MUL: begin
        cmd.close_mul = 1'b1;
        state_next    = S_CLOSE_ACC;
      end
      S_CLOSE_ACC: begin
        cmd.edge_acc = 1'b1;
        sel_next     = SEL_CX;
        state_next   = S_DIV_START;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          unique case (sel)
            SEL_CX: begin sel_next = SEL_CY; state_next = S_DIV_START; end
            SEL_CY: begin sel_next = SEL_MX; state_next = S_DIV_START; end
            SEL_MX: begin sel_next = SEL_MY; state_next = S_DIV_START; end
            default: state_next = S_LOAD;
          endcase
        end
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy) else $error("divide started while busy");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free) else $error("result load over pending result");
  a_take_acc: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> cmd.edge_acc) else $error("vertex transfer not followed by accumulate");
`endif

endmodule

>>> src/polygon_area_centroid.sv
// Top level of the polygon area and centroid block.
// Depends on pac_pkg, pac_ctrl, pac_datapath (which holds pac_divider).
//
// Usage: vertices arrive on in_valid/in_ready/in_data, one transfer per
// vertex; last_vertex closes the polygon. One result per polygon leaves on
// out_valid/out_ready/out_data. Each vertex is multiplied as it is taken
// and accumulated in the following state; intake takes no new vertex until
// that accumulate is done. The last vertex adds the closing edge (multiply,
// then accumulate) and four divisions on one shared bit-serial divider;
// a polygon of fewer than three vertices skips them and goes to the result
// load. cfg_we/cfg_index/cfg_data write image_width (index 0) and
// image_height (index 1), both 4096 after reset. Reset clears all polygon
// state and drops out_valid. The result sits in an output register; vertices
// of the next polygon keep transferring while it waits, and only the next
// result load holds until the receiver takes the pending one.
module polygon_area_centroid import pac_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  pac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pac_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
